### rtl/wspd_pkg.sv
// Package for the wheel speed unit: field widths, register reset values,
// fixed-point scale constants and the result quantity codes.
// No dependencies.
`timescale 1ns / 1ps

package wspd_pkg;

  // field and state widths
  localparam int TEETH_W  = 8;
  localparam int WIN_W    = 20;
  localparam int CIRC_W   = 13;
  localparam int CNT_W    = 32;
  localparam int OUT_W    = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 20;

  // arithmetic widths
  localparam int K_W      = 33;             // largest scale factor fits 33 bits
  localparam int K_LO_W   = 17;
  localparam int K_HI_W   = K_W - K_LO_W;
  localparam int MUL_A_W  = 32;
  localparam int MUL_B_W  = 20;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W    = CNT_W + K_W;    // numerator n * k
  localparam int DEN_W    = 40;             // period * teeth
  localparam int QCNT_W   = 5;

  // register reset values
  localparam logic [TEETH_W-1:0] TEETH_RST = TEETH_W'(48);
  localparam logic [WIN_W-1:0]   WIN_RST   = WIN_W'(50000);
  localparam logic [CIRC_W-1:0]  CIRC_RST  = CIRC_W'(2000);

  // scale factors
  localparam logic [K_W-1:0]     RPM_K     = 33'd6000000000;
  localparam logic [MUL_B_W-1:0] MMS_K     = 20'd1000000;
  localparam logic [MUL_B_W-1:0] KPH_K     = 20'd360000;
  localparam logic [OUT_W-1:0]   OUT_MAX   = {OUT_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEETH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CIRC  = 2'd2;

  // result quantities, computed in this order
  typedef enum logic [1:0] {
    Q_RPM,
    Q_MMS,
    Q_KPH
  } qty_t;

endpackage

### rtl/wheel_speed_from_hall_pulses_unit.sv
// Wheel speed unit top level: tick bookkeeping, sequencer, shared multiplier
// and shared restoring divider. Depends on wspd_pkg.
`timescale 1ns / 1ps

// Usage
// - in_*: one transfer per microsecond tick, in_edge_req flags a hall edge.
// - out_*: one transfer per closed measurement window: rpm, mm/s and km/h,
//   each saturated at 2^24-1, and a valid flag.
// - cfg_*: write enable, register index (0 teeth, 1 window, 2 circumference)
//   and data; write only while the unit is idle.
// Timing
// - a tick that does not close a window leaves the unit idle; ticks may
//   follow every cycle while the unit is idle.
// - a closing tick runs the sequencer: the denominator multiply, then per
//   quantity a scale factor step (a multiply except for rpm), two half
//   multiplies, one range check, a 24-step divide (skipped on saturation)
//   and a post step, and last the store into the output register; in_ready
//   is low while the sequencer runs. The shared 32x20 multiplier and the
//   one-bit-per-cycle divider do the arithmetic.
// - the output register frees the input side: ticks continue while a result
//   waits; only a second closing tick waits for the register to drain.
// Reset
// - synchronous active-low reset clears the counters, loads the default
//   registers (48 teeth, 50000 us window, 2000 mm) and drops out_valid.

module wheel_speed_from_hall_pulses_unit
  import wspd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // tick channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_edge_req,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_W-1:0]     out_rpm_centi,
  output logic [OUT_W-1:0]     out_speed_mm_per_s,
  output logic [OUT_W-1:0]     out_speed_kph_centi,
  output logic                 out_valid_res,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEN,
    S_KMUL,
    S_MLO,
    S_MHI,
    S_SAT,
    S_DIV,
    S_POST,
    S_OUT
  } state_t;

  state_t state_r;

  // configuration registers
  logic [TEETH_W-1:0] teeth_r;
  logic [WIN_W-1:0]   win_r;
  logic [CIRC_W-1:0]  circ_r;

  // tick bookkeeping
  logic [CNT_W-1:0] time_r, last_edge_r, period_r, total_r, start_r;
  logic [WIN_W-1:0] elapsed_r;

  // datapath
  logic [CNT_W-1:0]  num_r;
  logic [CNT_W-1:0]  den_a_r;
  logic [DEN_W-1:0]  den_r;
  logic [K_W-1:0]    k_r;
  logic [ACC_W-1:0]  acc_r;
  logic [DEN_W-1:0]  rem_r;
  logic [OUT_W-1:0]  q_r;
  logic [QCNT_W-1:0] cnt_r;
  qty_t              sel_r;
  logic [OUT_W-1:0]  rpm_r, mms_r;

  // output register
  logic             out_valid_r;
  logic [OUT_W-1:0] out_rpm_r, out_mms_r, out_kph_r;
  logic             out_vres_r;

  // effective register values, zero treated as one
  logic [TEETH_W-1:0] teeth_eff;
  logic [WIN_W-1:0]   win_eff;
  assign teeth_eff = (teeth_r == '0) ? TEETH_W'(1) : teeth_r;
  assign win_eff   = (win_r == '0) ? WIN_W'(1) : win_r;

  // tick update, evaluated on the transfer
  logic             in_xfer;
  logic [CNT_W-1:0] time_nxt, last_edge_nxt, period_nxt, total_nxt, n_win;
  logic [WIN_W-1:0] elapsed_nxt;
  logic             win_close;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    time_nxt      = time_r + CNT_W'(1);
    last_edge_nxt = last_edge_r;
    period_nxt    = period_r;
    total_nxt     = total_r;
    if (in_edge_req) begin
      period_nxt    = time_nxt - last_edge_r;
      last_edge_nxt = time_nxt;
      total_nxt     = total_r + CNT_W'(1);
    end
    elapsed_nxt = elapsed_r + WIN_W'(1);
    win_close   = (elapsed_nxt >= win_eff);
    n_win       = total_nxt - start_r;
  end

  // shared multiplier operand selection
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_DEN: begin
        mul_a = den_a_r;
        mul_b = MUL_B_W'(teeth_eff);
      end
      S_KMUL: begin
        mul_a = MUL_A_W'(circ_r);
        mul_b = (sel_r == Q_MMS) ? MMS_K : KPH_K;
      end
      S_MLO: begin
        mul_a = num_r;
        mul_b = MUL_B_W'(k_r[K_LO_W-1:0]);
      end
      S_MHI: begin
        mul_a = num_r;
        mul_b = MUL_B_W'(k_r[K_W-1:K_LO_W]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  // shared compare and subtract against the denominator
  logic [OUT_W-1:0] acc_lo;
  logic [DEN_W:0]   div_cand;
  logic [DEN_W:0]   cmp_a;
  logic [DEN_W+1:0] cmp_diff;
  logic             cmp_ge;

  assign acc_lo   = acc_r[OUT_W-1:0];
  assign div_cand = {rem_r, acc_lo[cnt_r]};
  assign cmp_a    = (state_r == S_SAT) ? acc_r[ACC_W-1:OUT_W] : div_cand;
  assign cmp_diff = {1'b0, cmp_a} - {2'b00, den_r};
  assign cmp_ge   = !cmp_diff[DEN_W+1];

  // sequencer, tick state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      teeth_r     <= TEETH_RST;
      win_r       <= WIN_RST;
      circ_r      <= CIRC_RST;
      time_r      <= '0;
      last_edge_r <= '0;
      period_r    <= '0;
      total_r     <= '0;
      start_r     <= '0;
      elapsed_r   <= '0;
      sel_r       <= Q_RPM;
      out_valid_r <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          REG_TEETH: teeth_r <= cfg_wdata[TEETH_W-1:0];
          REG_WIN:   win_r   <= cfg_wdata[WIN_W-1:0];
          REG_CIRC:  circ_r  <= cfg_wdata[CIRC_W-1:0];
          default:   ;
        endcase
      end

      // result transfer drains the output register, unless a new result loads it
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            time_r      <= time_nxt;
            last_edge_r <= last_edge_nxt;
            period_r    <= period_nxt;
            total_r     <= total_nxt;
            if (win_close) begin
              elapsed_r <= '0;
              start_r   <= total_nxt;
              // pulse count, else period fallback, else zero result
              if (n_win != '0) begin
                num_r   <= n_win;
                den_a_r <= CNT_W'(win_eff);
              end else if (period_nxt != '0) begin
                num_r   <= CNT_W'(1);
                den_a_r <= period_nxt;
              end else begin
                num_r   <= '0;
                den_a_r <= CNT_W'(1);
              end
              sel_r   <= Q_RPM;
              state_r <= S_DEN;
            end else begin
              elapsed_r <= elapsed_nxt;
            end
          end
        end
        S_DEN: begin
          den_r   <= mul_p[DEN_W-1:0];
          state_r <= S_KMUL;
        end
        S_KMUL: begin
          k_r     <= (sel_r == Q_RPM) ? RPM_K : mul_p[K_W-1:0];
          state_r <= S_MLO;
        end
        S_MLO: begin
          acc_r   <= ACC_W'(mul_p);
          state_r <= S_MHI;
        end
        S_MHI: begin
          acc_r   <= acc_r + {mul_p[CNT_W+K_HI_W-1:0], {K_LO_W{1'b0}}};
          state_r <= S_SAT;
        end
        // quotient of 2^24 or more saturates
        S_SAT: begin
          if (cmp_ge) begin
            q_r     <= OUT_MAX;
            state_r <= S_POST;
          end else begin
            rem_r   <= acc_r[OUT_W+DEN_W-1:OUT_W];
            q_r     <= '0;
            cnt_r   <= QCNT_W'(OUT_W - 1);
            state_r <= S_DIV;
          end
        end
        // one quotient bit per cycle
        S_DIV: begin
          rem_r <= cmp_ge ? cmp_diff[DEN_W-1:0] : div_cand[DEN_W-1:0];
          q_r   <= {q_r[OUT_W-2:0], cmp_ge};
          if (cnt_r == '0) begin
            state_r <= S_POST;
          end else begin
            cnt_r <= cnt_r - QCNT_W'(1);
          end
        end
        S_POST: begin
          case (sel_r)
            Q_RPM: begin
              rpm_r   <= q_r;
              sel_r   <= Q_MMS;
              state_r <= S_KMUL;
            end
            Q_MMS: begin
              mms_r   <= q_r;
              sel_r   <= Q_KPH;
              state_r <= S_KMUL;
            end
            default: begin
              state_r <= S_OUT;
            end
          endcase
        end
        // wait for a free output register
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_rpm_r   <= rpm_r;
            out_mms_r   <= mms_r;
            out_kph_r   <= q_r;
            out_vres_r  <= (rpm_r > OUT_W'(1));
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_rpm_centi       = out_rpm_r;
  assign out_speed_mm_per_s  = out_mms_r;
  assign out_speed_kph_centi = out_kph_r;
  assign out_valid_res       = out_vres_r;

  // valid flag follows the rpm value
  a_vres_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_vres_r == (out_rpm_r > OUT_W'(1))))
    else $error("valid_res does not match rpm");

  // divider remainder stays below the denominator
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < den_r))
    else $error("divider remainder out of range");

  // denominator is never zero while dividing
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SAT || state_r == S_DIV) |-> (den_r != '0))
    else $error("zero denominator");

  // a tick that does not close a window leaves the unit ready
  a_tick_single: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !win_close) |=> (state_r == S_IDLE))
    else $error("non-closing tick left idle");

  // a closing tick starts the denominator multiply next cycle
  a_close_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && win_close) |=> (state_r == S_DEN && elapsed_r == '0))
    else $error("closing tick did not start the computation");

endmodule
